@@ design/ust_pkg.sv @@
// ----------------------------------------------------------------------------
// Unsorted set table package
// Shared widths, codes and types for the unsorted set table.
// ----------------------------------------------------------------------------
package ust_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int OUT_CNT_W = 5;

	typedef enum logic [1:0] {
		ACT_ADD      = 2'd0,
		ACT_CONTAINS = 2'd1,
		ACT_REMOVE   = 2'd2,
		ACT_CLEAR    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic             busy;
		logic [VAL_W-1:0] value;
		logic [CNT_W-1:0] count;
		logic             found;
		logic [IDX_W-1:0] pos;
		logic [VAL_W-1:0] last;
	} query_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		logic [VAL_W-1:0] data;
	} write_t;

endpackage

@@ design/ust_req_if.sv @@
// ----------------------------------------------------------------------------
// Unsorted set table request channel
// Carries one action and value per word.
// ----------------------------------------------------------------------------
interface ust_req_if;

	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic signed [ust_pkg::VAL_W-1:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);

endinterface

@@ design/ust_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Unsorted set table response channel
// Carries one result word per request word.
// ----------------------------------------------------------------------------
interface ust_rsp_if;

	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic                          full_res;
	logic [ust_pkg::OUT_CNT_W-1:0] entry_count;

	modport source (output valid, output hit, output full_res, output entry_count,
		input ready);
	modport sink (input valid, input hit, input full_res, input entry_count,
		output ready);

endinterface

@@ design/ust_cell.sv @@
// ----------------------------------------------------------------------------
// Unsorted set table cell
// Holds one table entry and passes the search query on to its neighbour.
// ----------------------------------------------------------------------------
module ust_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [ust_pkg::IDX_W-1:0] idx,
	input  ust_pkg::write_t        wr,
	input  ust_pkg::query_t        q_in,
	output ust_pkg::query_t        q_out
);

	logic [ust_pkg::VAL_W-1:0] entry_q;
	ust_pkg::query_t           next_q;
	ust_pkg::query_t           q_q;
	logic [ust_pkg::CNT_W-1:0] idx_c;
	logic                      live;

	assign idx_c = ust_pkg::CNT_W'(idx);
	assign live  = idx_c < q_in.count;

	always_comb begin
		next_q = q_in;
		if (!q_in.found && live && (entry_q == q_in.value)) begin
			next_q.found = 1'b1;
			next_q.pos   = idx;
		end
		if (idx_c + ust_pkg::CNT_W'(1) == q_in.count) begin
			next_q.last = entry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == idx)) begin
			entry_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
		end else begin
			q_q <= next_q;
		end
	end

	assign q_out = q_q;

endmodule

@@ design/unsorted_set_table.sv @@
// ----------------------------------------------------------------------------
// Unsorted set table
// Fixed-depth unsorted set of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
// Each request word on req carries an action (add, contains, remove, clear)
// and a value; exactly one result word leaves on rsp for every request.
// The result gives hit, full_res and the live entry count after the action.
// Add and clear do not use the cell row: the request is registered, then the
// result and any table write are registered in the finish state once the
// result register is free. Contains and remove send a query down the row of
// DEPTH cells, one cell per cycle, and the end of the row is registered
// before the finish state; a remove then copies the last live entry into the
// matched slot as the result is registered. One request is worked on at a
// time; req.ready is high whenever no request is in progress, also while a
// finished result waits on rsp.
// When the receiver stalls, the result register holds its word and a request
// in progress waits at its last step until the register is free.
// Reset empties the table at once; entry contents are left as they are and
// are only read after being written again.
// ----------------------------------------------------------------------------
module unsorted_set_table (
	input  logic    clk,
	input  logic    arst_n,
	ust_req_if.sink req,
	ust_rsp_if.source rsp
);

	ust_pkg::state_t           state_q;
	ust_pkg::state_t           state_d;
	ust_pkg::action_t          act_q;
	logic [ust_pkg::VAL_W-1:0] value_q;
	logic [ust_pkg::CNT_W-1:0] count_q;
	logic [ust_pkg::CNT_W-1:0] count_d;
	logic                      found_q;
	logic [ust_pkg::IDX_W-1:0] pos_q;
	logic [ust_pkg::VAL_W-1:0] last_q;
	logic                      out_valid_q;
	logic                      hit_q;
	logic                      full_q;
	logic [ust_pkg::OUT_CNT_W-1:0] out_count_q;
	logic                      hit_d;
	logic                      full_d;
	logic                      finish;
	logic                      out_free;
	logic                      accept;
	logic                      is_full;
	logic [ust_pkg::CNT_W+ust_pkg::OUT_CNT_W-1:0] count_wide;
	ust_pkg::write_t           wr;
	ust_pkg::query_t           link [ust_pkg::DEPTH+1];

	assign req.ready = (state_q == ust_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign is_full   = count_q >= ust_pkg::CNT_W'(ust_pkg::DEPTH);

	always_comb begin
		link[0]       = '0;
		link[0].busy  = accept && ((ust_pkg::action_t'(req.action) == ust_pkg::ACT_CONTAINS) ||
			(ust_pkg::action_t'(req.action) == ust_pkg::ACT_REMOVE));
		link[0].value = req.value;
		link[0].count = count_q;
	end

	for (genvar i = 0; i < ust_pkg::DEPTH; i++) begin : g_cell
		ust_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (ust_pkg::IDX_W'(i)),
			.wr     (wr),
			.q_in   (link[i]),
			.q_out  (link[i+1])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ust_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (ust_pkg::action_t'(req.action)) inside
						ust_pkg::ACT_CONTAINS, ust_pkg::ACT_REMOVE: state_d = ust_pkg::ST_SCAN;
						default: state_d = ust_pkg::ST_FINISH;
					endcase
				end
			end
			ust_pkg::ST_SCAN: begin
				if (link[ust_pkg::DEPTH].busy) begin
					state_d = ust_pkg::ST_FINISH;
				end
			end
			ust_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = ust_pkg::ST_IDLE;
				end
			end
			default: state_d = ust_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		finish  = (state_q == ust_pkg::ST_FINISH) && out_free;
		wr      = '0;
		count_d = count_q;
		hit_d   = 1'b0;
		full_d  = 1'b0;
		unique case (act_q)
			ust_pkg::ACT_ADD: begin
				if (is_full) begin
					full_d = 1'b1;
				end else begin
					wr.en   = finish;
					wr.idx  = count_q[ust_pkg::IDX_W-1:0];
					wr.data = value_q;
					count_d = count_q + ust_pkg::CNT_W'(1);
					hit_d   = 1'b1;
				end
			end
			ust_pkg::ACT_CONTAINS: begin
				hit_d = found_q;
			end
			ust_pkg::ACT_REMOVE: begin
				if (found_q) begin
					wr.en   = finish;
					wr.idx  = pos_q;
					wr.data = last_q;
					count_d = count_q - ust_pkg::CNT_W'(1);
					hit_d   = 1'b1;
				end
			end
			ust_pkg::ACT_CLEAR: begin
				count_d = '0;
			end
			default: count_d = count_q;
		endcase
	end

	assign count_wide = {{ust_pkg::OUT_CNT_W{1'b0}}, count_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ust_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q   <= ust_pkg::action_t'(req.action);
			value_q <= req.value;
		end
		if ((state_q == ust_pkg::ST_SCAN) && link[ust_pkg::DEPTH].busy) begin
			found_q <= link[ust_pkg::DEPTH].found;
			pos_q   <= link[ust_pkg::DEPTH].pos;
			last_q  <= link[ust_pkg::DEPTH].last;
		end else if (accept) begin
			found_q <= 1'b0;
		end
		if (finish) begin
			hit_q       <= hit_d;
			full_q      <= full_d;
			out_count_q <= count_wide[ust_pkg::OUT_CNT_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.full_res    = full_q;
	assign rsp.entry_count = out_count_q;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Unsorted set table testbench
// A driver and a monitor exchange words with the table through its request
// and response channels. A shadow copy of the table predicts every result
// word, which the monitor then checks field by field. A directed opening
// covers the corner cases, and bursts that lean towards filling or towards
// draining follow it. Both sides idle in rotating phases.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned RANDOM_OPS = 1250;
	localparam int unsigned POOL_SIZE = 12;

	typedef struct packed {
		ust_pkg::action_t                 act;
		logic signed [ust_pkg::VAL_W-1:0] value;
	} op_t;

	typedef struct packed {
		logic                          hit;
		logic                          full_res;
		logic [ust_pkg::OUT_CNT_W-1:0] entry_count;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ust_req_if req_ch ();
	ust_rsp_if rsp_ch ();

	unsorted_set_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	op_t         pending_ops[$];
	result_t     due_results[$];
	op_t         cur_op;
	logic [31:0] shadow[ust_pkg::DEPTH];
	int unsigned shadow_count = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked = 0;
	int unsigned n_errors = 0;
	int unsigned n_stored = 0;
	int unsigned n_dropped = 0;
	int unsigned n_found = 0;
	int unsigned n_removed = 0;
	int unsigned n_missed = 0;
	int unsigned n_cleared = 0;
	int unsigned cycle = 0;

	always #1 clk = ~clk;

	function automatic result_t shadow_apply(op_t op);
		result_t r;
		int      pos;
		r = '0;
		pos = -1;
		if (op.act == ust_pkg::ACT_CONTAINS || op.act == ust_pkg::ACT_REMOVE) begin
			for (int i = 0; i < int'(shadow_count); i++) begin
				if (pos < 0 && shadow[i] == op.value)
					pos = i;
			end
		end
		case (op.act)
			ust_pkg::ACT_ADD: begin
				if (shadow_count >= ust_pkg::DEPTH) begin
					r.full_res = 1'b1;
					n_dropped++;
				end else begin
					shadow[shadow_count] = op.value;
					shadow_count++;
					r.hit = 1'b1;
					n_stored++;
				end
			end
			ust_pkg::ACT_CONTAINS: begin
				r.hit = (pos >= 0);
				if (pos >= 0)
					n_found++;
				else
					n_missed++;
			end
			ust_pkg::ACT_REMOVE: begin
				if (pos >= 0) begin
					shadow[pos] = shadow[shadow_count - 1];
					shadow_count--;
					r.hit = 1'b1;
					n_removed++;
				end else begin
					n_missed++;
				end
			end
			default: begin
				shadow_count = 0;
				n_cleared++;
			end
		endcase
		r.entry_count = shadow_count[ust_pkg::OUT_CNT_W-1:0];
		return r;
	endfunction

	// The idle pattern rotates every 80 accepted words: none, sender, receiver, both.
	function automatic int unsigned idle_pct(bit receiver);
		case ((n_accepted / 80) % 4)
			1: return receiver ? 0 : 72;
			2: return receiver ? 72 : 0;
			3: return 30;
			default: return 0;
		endcase
	endfunction

	task automatic push_op(ust_pkg::action_t act, logic signed [ust_pkg::VAL_W-1:0] value);
		op_t op;
		op.act = act;
		op.value = value;
		pending_ops.push_back(op);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.action <= ust_pkg::ACT_ADD;
			req_ch.value <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				due_results.push_back(shadow_apply(cur_op));
				n_accepted <= n_accepted + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					cur_op = pending_ops.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.action <= cur_op.act;
					req_ch.value <= cur_op.value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("result word with no request outstanding");
					n_errors++;
				end else begin
					result_t want;
					want = due_results.pop_front();
					n_checked++;
					if (rsp_ch.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, rsp_ch.hit);
						n_errors++;
					end
					if (rsp_ch.full_res !== want.full_res) begin
						$error("full_res: expected %0d, got %0d", want.full_res,
							rsp_ch.full_res);
						n_errors++;
					end
					if (rsp_ch.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							rsp_ch.entry_count);
						n_errors++;
					end
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= idle_pct(1'b1));
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d words still outstanding", cycle,
				due_results.size() + pending_ops.size());
			$display("** unsorted_set_table: FAILED **");
			$finish;
		end
	end

	initial begin
		logic signed [ust_pkg::VAL_W-1:0] fill[ust_pkg::DEPTH];
		logic signed [ust_pkg::VAL_W-1:0] pool[POOL_SIZE];
		logic signed [ust_pkg::VAL_W-1:0] val;
		int unsigned                      n_rand;
		int unsigned                      burst_len;
		int unsigned                      roll;
		bit                               draining;
		ust_pkg::action_t                 act;

		req_ch.valid = 1'b0;
		req_ch.action = ust_pkg::ACT_ADD;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;

		fill[0] = 32'sh8000_0000;
		fill[1] = 32'sh7fff_ffff;
		fill[2] = 32'sh0000_0000;
		fill[3] = 32'shffff_ffff;
		fill[4] = 32'sh0000_0001;
		fill[5] = 32'sh5555_5555;
		fill[6] = 32'shaaaa_aaaa;
		for (int i = 7; i < ust_pkg::DEPTH; i++)
			fill[i] = $urandom;

		push_op(ust_pkg::ACT_CLEAR, 32'sh0);
		push_op(ust_pkg::ACT_REMOVE, fill[0]);
		push_op(ust_pkg::ACT_CONTAINS, fill[2]);
		for (int i = 0; i < ust_pkg::DEPTH; i++)
			push_op(ust_pkg::ACT_ADD, fill[i]);
		push_op(ust_pkg::ACT_ADD, 32'sh1234_5678);
		push_op(ust_pkg::ACT_CONTAINS, fill[1]);
		push_op(ust_pkg::ACT_CONTAINS, 32'sh1234_5678);
		push_op(ust_pkg::ACT_REMOVE, fill[0]);
		push_op(ust_pkg::ACT_REMOVE, fill[ust_pkg::DEPTH-2]);
		push_op(ust_pkg::ACT_REMOVE, 32'sh1234_5678);
		push_op(ust_pkg::ACT_CLEAR, 32'shffff_ffff);

		pool[0] = 32'sh8000_0000;
		pool[1] = 32'sh7fff_ffff;
		pool[2] = 32'sh0000_0000;
		pool[3] = 32'shffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			pool[i] = $urandom;

		n_rand = 0;
		while (n_rand < RANDOM_OPS) begin
			burst_len = $urandom_range(60, 20);
			draining = $urandom_range(1);
			pool[$urandom_range(POOL_SIZE - 1, 4)] = $urandom;
			for (int k = 0; k < int'(burst_len); k++) begin
				roll = $urandom_range(99);
				if (roll < 2)
					act = ust_pkg::ACT_CLEAR;
				else if (roll < (draining ? 22 : 60))
					act = ust_pkg::ACT_ADD;
				else if (roll < (draining ? 47 : 80))
					act = ust_pkg::ACT_CONTAINS;
				else
					act = ust_pkg::ACT_REMOVE;
				if ($urandom_range(3) == 0)
					val = $urandom;
				else
					val = pool[$urandom_range(POOL_SIZE - 1)];
				push_op(act, val);
				n_rand++;
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || req_ch.valid || due_results.size() != 0)
			@(posedge clk);
		repeat (ust_pkg::DEPTH + 4) @(posedge clk);

		$display("%0d result words checked: %0d values stored, %0d adds refused on a full table,",
			n_checked, n_stored, n_dropped);
		$display("%0d lookups found, %0d entries removed, %0d misses, %0d clears, %0d errors",
			n_found, n_removed, n_missed, n_cleared, n_errors);
		if (n_errors == 0)
			$display("** unsorted_set_table: PASSED **");
		else
			$display("** unsorted_set_table: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
design/ust_pkg.sv
design/ust_req_if.sv
design/ust_rsp_if.sv
design/ust_cell.sv
design/unsorted_set_table.sv
dv/tb_top.sv
